>>> rtl/core/tlfd_pkg.sv
package tlfd_pkg;

  // Default geometry
  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned PidWidthDefault   = 8;

  // Field widths fixed by the interface
  localparam int unsigned CmdWidth   = 2;
  localparam int unsigned ModeWidth  = 2;
  localparam int unsigned LimitWidth = 7;
  localparam int unsigned QselWidth  = 2;
  localparam int unsigned StatWidth  = 2;
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CfgDataWidth = 7;

  // Commands
  localparam logic [CmdWidth-1:0] CMD_NEW      = 2'd0;
  localparam logic [CmdWidth-1:0] CMD_EXPIRED  = 2'd1;
  localparam logic [CmdWidth-1:0] CMD_UNBLOCK  = 2'd2;
  localparam logic [CmdWidth-1:0] CMD_DISPATCH = 2'd3;

  // Scheduling modes
  localparam logic [ModeWidth-1:0] MODE_FCFS     = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_RR       = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_FEEDBACK = 2'd2;

  // Queue codes
  localparam logic [QselWidth-1:0] Q_HIGH = 2'd0;
  localparam logic [QselWidth-1:0] Q_LOW  = 2'd1;
  localparam logic [QselWidth-1:0] Q_WAIT = 2'd2;

  // Status codes
  localparam logic [StatWidth-1:0] ST_OK   = 2'd0;
  localparam logic [StatWidth-1:0] ST_FULL = 2'd1;
  localparam logic [StatWidth-1:0] ST_IDLE = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] REG_MODE  = 1'd0;
  localparam logic [CfgIdxWidth-1:0] REG_LIMIT = 1'd1;

  localparam logic [ModeWidth-1:0]  ModeReset  = MODE_FCFS;
  localparam logic [LimitWidth-1:0] LimitReset = 7'd4;

  // Result flags that travel from the queue controller to the top level
  typedef struct packed {
    logic                 dispatched;
    logic                 arm_quantum;
    logic [QselWidth-1:0] source_queue;
    logic [StatWidth-1:0] status;
  } tlfd_result_t;

endpackage

>>> rtl/core/tlfd_pid_mem.sv
module tlfd_pid_mem import tlfd_pkg::*; #(
  parameter int unsigned Depth = 3 * QueueDepthDefault,
  parameter int unsigned Width = PidWidthDefault,
  localparam int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] addr_i,
  input  logic [Width-1:0]     wdata_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tlfd_queue_ctrl.sv
module tlfd_queue_ctrl import tlfd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault,
  parameter int unsigned PidWidth   = PidWidthDefault,
  localparam int unsigned MemDepth  = 3 * QueueDepth,
  localparam int unsigned AddrWidth = $clog2(MemDepth)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [ModeWidth-1:0]  mode_i,
  input  logic [LimitWidth-1:0] limit_i,
  input  logic [CmdWidth-1:0]   command_i,
  input  logic [PidWidth-1:0]   pid_i,
  output logic                  mem_we_o,
  output logic                  mem_re_o,
  output logic [AddrWidth-1:0]  mem_addr_o,
  output logic [PidWidth-1:0]   mem_wdata_o,
  output logic                  res_valid_o,
  output tlfd_result_t          res_o
);

  localparam int unsigned IdxWidth = $clog2(QueueDepth);
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);
  localparam int unsigned SumWidth = CntWidth + 1;
  localparam int unsigned CmpWidth = (CntWidth > LimitWidth) ? CntWidth : LimitWidth;
  localparam logic [CntWidth-1:0]  CntFull  = CntWidth'(QueueDepth);
  localparam logic [IdxWidth-1:0]  IdxLast  = IdxWidth'(QueueDepth - 1);
  localparam logic [SumWidth-1:0]  SumDepth = SumWidth'(QueueDepth);
  localparam logic [AddrWidth-1:0] BaseLow  = AddrWidth'(QueueDepth);
  localparam logic [AddrWidth-1:0] BaseWait = AddrWidth'(2 * QueueDepth);

  logic [IdxWidth-1:0] head_high_q, head_low_q, head_wait_q;
  logic [IdxWidth-1:0] head_high_d, head_low_d, head_wait_d;
  logic [CntWidth-1:0] cnt_high_q, cnt_low_q, cnt_wait_q;
  logic [CntWidth-1:0] cnt_high_d, cnt_low_d, cnt_wait_d;

  logic                 feedback;
  logic                 is_pop;
  logic                 do_push;
  logic                 do_pop;
  logic [QselWidth-1:0] qsel;
  logic [IdxWidth-1:0]  sel_head;
  logic [CntWidth-1:0]  sel_cnt;
  logic [SumWidth-1:0]  slot_sum;
  logic [IdxWidth-1:0]  slot;
  logic [IdxWidth-1:0]  index;
  logic [IdxWidth-1:0]  head_next;
  logic [AddrWidth-1:0] base;
  tlfd_result_t         res_c;
  tlfd_result_t         res_d, res_q;
  logic                 valid_q;

  assign feedback = (mode_i == MODE_FEEDBACK);
  assign is_pop   = (command_i == CMD_DISPATCH);

  // Pick the queue to touch and the flags of the result beat
  always_comb begin
    qsel  = Q_HIGH;
    res_c = '0;
    if (is_pop) begin
      if (cnt_high_q != '0) begin
        qsel = Q_HIGH;
        res_c.dispatched = 1'b1;
      end else if (feedback && (cnt_low_q != '0)) begin
        qsel = Q_LOW;
        res_c.dispatched = 1'b1;
      end else if (cnt_wait_q != '0) begin
        qsel = Q_WAIT;
        res_c.dispatched = 1'b1;
      end else begin
        res_c.status = ST_IDLE;
      end
      res_c.arm_quantum = res_c.dispatched &&
                          ((mode_i == MODE_RR) || (feedback && (qsel == Q_HIGH)));
      res_c.source_queue = res_c.dispatched ? qsel : Q_HIGH;
    end else begin
      case (command_i)
        CMD_NEW: begin
          qsel = (CmpWidth'(cnt_high_q) < CmpWidth'(limit_i)) ? Q_HIGH : Q_WAIT;
        end
        CMD_EXPIRED: begin
          qsel = feedback ? Q_LOW : Q_HIGH;
        end
        default: begin
          qsel = Q_HIGH;
        end
      endcase
      res_c.source_queue = qsel;
    end
  end

  always_comb begin
    case (qsel)
      Q_LOW: begin
        sel_head = head_low_q;
        sel_cnt  = cnt_low_q;
        base     = BaseLow;
      end
      Q_WAIT: begin
        sel_head = head_wait_q;
        sel_cnt  = cnt_wait_q;
        base     = BaseWait;
      end
      default: begin
        sel_head = head_high_q;
        sel_cnt  = cnt_high_q;
        base     = '0;
      end
    endcase
  end

  // Tail slot wraps at the queue depth, which need not be a power of two
  assign slot_sum  = SumWidth'(sel_head) + SumWidth'(sel_cnt);
  assign slot      = (slot_sum >= SumDepth) ? IdxWidth'(slot_sum - SumDepth)
                                            : IdxWidth'(slot_sum);
  assign head_next = (sel_head == IdxLast) ? '0 : sel_head + IdxWidth'(1);

  // Drop a push into a full queue and flag it
  always_comb begin
    res_d   = res_c;
    do_push = accept_i && !is_pop;
    do_pop  = accept_i && res_c.dispatched;
    if (!is_pop && (sel_cnt == CntFull)) begin
      do_push       = 1'b0;
      res_d.status  = ST_FULL;
    end
  end

  assign index       = is_pop ? sel_head : slot;
  assign mem_addr_o  = base + AddrWidth'(index);
  assign mem_we_o    = do_push;
  assign mem_re_o    = do_pop;
  assign mem_wdata_o = pid_i;

  // Advance head on a pop, bump or drop the count
  always_comb begin
    head_high_d = head_high_q;
    head_low_d  = head_low_q;
    head_wait_d = head_wait_q;
    cnt_high_d  = cnt_high_q;
    cnt_low_d   = cnt_low_q;
    cnt_wait_d  = cnt_wait_q;
    if (do_pop) begin
      case (qsel)
        Q_LOW: begin
          head_low_d = head_next;
          cnt_low_d  = cnt_low_q - CntWidth'(1);
        end
        Q_WAIT: begin
          head_wait_d = head_next;
          cnt_wait_d  = cnt_wait_q - CntWidth'(1);
        end
        default: begin
          head_high_d = head_next;
          cnt_high_d  = cnt_high_q - CntWidth'(1);
        end
      endcase
    end else if (do_push) begin
      case (qsel)
        Q_LOW:   cnt_low_d  = cnt_low_q + CntWidth'(1);
        Q_WAIT:  cnt_wait_d = cnt_wait_q + CntWidth'(1);
        default: cnt_high_d = cnt_high_q + CntWidth'(1);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_high_q <= '0;
      head_low_q  <= '0;
      head_wait_q <= '0;
      cnt_high_q  <= '0;
      cnt_low_q   <= '0;
      cnt_wait_q  <= '0;
      valid_q     <= 1'b0;
    end else begin
      head_high_q <= head_high_d;
      head_low_q  <= head_low_d;
      head_wait_q <= head_wait_d;
      cnt_high_q  <= cnt_high_d;
      cnt_low_q   <= cnt_low_d;
      cnt_wait_q  <= cnt_wait_d;
      valid_q     <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/two_level_feedback_dispatcher.sv
// A result beat appears on valid_o in the cycle after start_i is taken.
// Throughput: one command per cycle; busy_o stays low, so start_i may be held
// high every cycle. Each command does at most one push or one pop on a shared PID RAM.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
// Reset (rst_ni, async, active low) empties all three queues, sets the mode
// to first-come first-served and the admission limit to four.
module two_level_feedback_dispatcher import tlfd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault,
  parameter int unsigned PidWidth   = PidWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // command channel
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [CmdWidth-1:0]     command_i,
  input  logic [PidWidth-1:0]     process_id_i,
  // result channel
  output logic                    valid_o,
  output logic                    dispatched_o,
  output logic [PidWidth-1:0]     dispatched_pid_o,
  output logic                    arm_quantum_o,
  output logic [QselWidth-1:0]    source_queue_o,
  output logic [StatWidth-1:0]    status_o,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  // The three queues share one RAM: high ready, low ready, then waiting,
  // each QueueDepth words.
  localparam int unsigned MemDepth  = 3 * QueueDepth;
  localparam int unsigned AddrWidth = $clog2(MemDepth);

  logic [ModeWidth-1:0]  mode_q;
  logic [LimitWidth-1:0] limit_q;
  logic                  accept;
  logic                  mem_we;
  logic                  mem_re;
  logic [AddrWidth-1:0]  mem_addr;
  logic [PidWidth-1:0]   mem_wdata;
  logic [PidWidth-1:0]   mem_rdata;
  logic                  res_valid;
  tlfd_result_t          res;

  // The RAM read returns in the cycle after the pop, exactly when the
  // result beat goes out. A push in that cycle lands on the tail, which
  // differs from the entry just read unless the queue was full, and then
  // the read data is already captured. A pop right after a push sees the
  // written word because the write completed at the earlier edge.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Config regs: user writes only while no command is in flight; not checked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeReset;
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:  mode_q  <= cfg_wdata_i[ModeWidth-1:0];
        REG_LIMIT: limit_q <= cfg_wdata_i[LimitWidth-1:0];
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  tlfd_queue_ctrl #(
    .QueueDepth (QueueDepth),
    .PidWidth   (PidWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_q),
    .limit_i     (limit_q),
    .command_i   (command_i),
    .pid_i       (process_id_i),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tlfd_pid_mem #(
    .Depth (MemDepth),
    .Width (PidWidth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Drive the result beat; the PID reads as zero unless a process was popped
  assign valid_o          = res_valid;
  assign dispatched_o     = res.dispatched;
  assign dispatched_pid_o = res.dispatched ? mem_rdata : '0;
  assign arm_quantum_o    = res.arm_quantum;
  assign source_queue_o   = res.source_queue;
  assign status_o         = res.status;

endmodule

>>> tb/sv/tb.sv
module tb import tlfd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth         = QueueDepthDefault;
  localparam int unsigned PidWidth      = PidWidthDefault;
  localparam int unsigned RandomItems   = 1550;
  localparam int unsigned IdleLowPct    = 6;
  localparam int unsigned IdleHighPct   = 58;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned CycleLimit    = 200_000;
  // Mode code left unnamed by the package; the block treats it as first-come first-served.
  localparam logic [ModeWidth-1:0] MODE_RESERVED = 2'd3;

  // One result beat as the block reports it.
  typedef struct packed {
    logic                 dispatched;
    logic [PidWidth-1:0]  pid;
    logic                 arm;
    logic [QselWidth-1:0] src;
    logic [StatWidth-1:0] st;
  } sched_result_t;

  // One row of the directed sequence: either a register write or a command beat,
  // the latter optionally carrying a hand-written expectation.
  typedef struct {
    logic                    is_cfg;
    logic [CfgIdxWidth-1:0]  idx;
    logic [CfgDataWidth-1:0] data;
    logic [CmdWidth-1:0]     cmd;
    logic [PidWidth-1:0]     pid;
    logic                    pinned;
    sched_result_t           want;
  } step_t;

  // Every block input holds a known value from time zero.
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    start_i      = 1'b0;
  logic [CmdWidth-1:0]     command_i    = CMD_NEW;
  logic [PidWidth-1:0]     process_id_i = '0;
  logic                    cfg_we_i     = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i    = REG_MODE;
  logic [CfgDataWidth-1:0] cfg_wdata_i  = '0;
  logic                    busy_o;
  logic                    valid_o;
  logic                    dispatched_o;
  logic [PidWidth-1:0]     dispatched_pid_o;
  logic                    arm_quantum_o;
  logic [QselWidth-1:0]    source_queue_o;
  logic [StatWidth-1:0]    status_o;

  // Sideband that travels with a directed beat: use the typed-in expectation.
  logic          pin_en     = 1'b0;
  sched_result_t pin_result = '0;

  // Shadow of the dispatcher: three rings indexed by queue code, plus registers.
  logic [PidWidth-1:0]   ring_pid  [3][Depth];
  int unsigned           ring_head [3] = '{0, 0, 0};
  int unsigned           ring_fill [3] = '{0, 0, 0};
  logic [ModeWidth-1:0]  sched_mode = ModeReset;
  logic [LimitWidth-1:0] admit_lim  = LimitReset;

  sched_result_t pending_results [$];
  int unsigned   mismatches = 0;
  int unsigned   cycles     = 0;

  two_level_feedback_dispatcher i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .process_id_i    (process_id_i),
    .valid_o         (valid_o),
    .dispatched_o    (dispatched_o),
    .dispatched_pid_o(dispatched_pid_o),
    .arm_quantum_o   (arm_quantum_o),
    .source_queue_o  (source_queue_o),
    .status_o        (status_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advance the shadow by one command and return the beat it should produce.
  function automatic sched_result_t schedule_cmd(input logic [CmdWidth-1:0] cmd,
                                                 input logic [PidWidth-1:0] pid);
    sched_result_t        r;
    logic [QselWidth-1:0] q;
    logic                 feedback;
    logic                 found;
    r = '0;
    q = Q_HIGH;
    feedback = (sched_mode == MODE_FEEDBACK);
    if (cmd == CMD_DISPATCH) begin
      // Serve high first; low only in feedback mode; waiting last.
      found = 1'b1;
      if (ring_fill[Q_HIGH] != 0) q = Q_HIGH;
      else if (feedback && ring_fill[Q_LOW] != 0) q = Q_LOW;
      else if (ring_fill[Q_WAIT] != 0) q = Q_WAIT;
      else found = 1'b0;
      if (found) begin
        r.dispatched = 1'b1;
        r.pid = ring_pid[q][ring_head[q]];
        r.src = q;
        r.arm = (sched_mode == MODE_RR) || (feedback && q == Q_HIGH);
        ring_head[q] = (ring_head[q] + 1) % Depth;
        ring_fill[q]--;
      end else begin
        r.st = ST_IDLE;
      end
    end else begin
      if (cmd == CMD_NEW) q = (ring_fill[Q_HIGH] < admit_lim) ? Q_HIGH : Q_WAIT;
      else if (cmd == CMD_EXPIRED) q = feedback ? Q_LOW : Q_HIGH;
      else q = Q_HIGH;
      r.src = q;
      // Drop the push on a full ring; state stays as it was.
      if (ring_fill[q] >= Depth) begin
        r.st = ST_FULL;
      end else begin
        ring_pid[q][(ring_head[q] + ring_fill[q]) % Depth] = pid;
        ring_fill[q]++;
      end
    end
    return r;
  endfunction

  task automatic report_field(input string name, input int unsigned want, input int unsigned got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    mismatches++;
  endtask

  // Monitor: sample at the rising edge. Take the config write or the accepted
  // command beat into the shadow first, then check any result beat on the port.
  always @(posedge clk_i) begin
    sched_result_t want;
    sched_result_t pred;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MODE) sched_mode = cfg_wdata_i[ModeWidth-1:0];
        else admit_lim = cfg_wdata_i[LimitWidth-1:0];
      end
      if (start_i && !busy_o) begin
        pred = schedule_cmd(command_i, process_id_i);
        pending_results.push_back(pin_en ? pin_result : pred);
      end
      if (valid_o === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got pid %0h status %0h",
                   $time, dispatched_pid_o, status_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (dispatched_o !== want.dispatched)
            report_field("dispatched", want.dispatched, dispatched_o);
          if (dispatched_pid_o !== want.pid)
            report_field("dispatched_pid", want.pid, dispatched_pid_o);
          if (arm_quantum_o !== want.arm)
            report_field("arm_quantum", want.arm, arm_quantum_o);
          if (source_queue_o !== want.src)
            report_field("source_queue", want.src, source_queue_o);
          if (status_o !== want.st)
            report_field("status", want.st, status_o);
        end
      end
    end
  end

  function automatic step_t cmd_step(input logic [CmdWidth-1:0] cmd,
                                     input logic [PidWidth-1:0] pid);
    step_t s;
    s = '{is_cfg: 1'b0, idx: REG_MODE, data: '0, cmd: cmd, pid: pid,
          pinned: 1'b0, want: '0};
    return s;
  endfunction

  function automatic step_t pinned_step(input logic [CmdWidth-1:0] cmd,
                                        input logic [PidWidth-1:0] pid,
                                        input sched_result_t want);
    step_t s;
    s = cmd_step(cmd, pid);
    s.pinned = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic step_t cfg_step(input logic [CfgIdxWidth-1:0] idx,
                                     input logic [CfgDataWidth-1:0] data);
    step_t s;
    s = cmd_step(CMD_NEW, '0);
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  // Drive one command beat. Called and returns at a falling edge; hold start_i
  // high across back-to-back beats, drop it only for idle cycles.
  task automatic send_cmd(input logic [CmdWidth-1:0] cmd, input logic [PidWidth-1:0] pid,
                          input logic pinned, input sched_result_t want,
                          input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    command_i    <= cmd;
    process_id_i <= pid;
    pin_en       <= pinned;
    pin_result   <= want;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Stop sending, let every expected beat come back, then let the pipe settle.
  task automatic quiesce();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Register write while the block is idle; one write enable pulse.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    step_t                 steps [$];
    int unsigned           sent;
    int unsigned           n;
    int unsigned           kind;
    int unsigned           lane;
    int unsigned           idle;
    logic [ModeWidth-1:0]  mode;
    logic [LimitWidth-1:0] lim;
    logic [CmdWidth-1:0]   cmd;

    // Directed part. Starts from reset: first-come first-served, admission limit four.
    steps.push_back(pinned_step(CMD_DISPATCH, 8'hFF, '{1'b0, 8'h00, 1'b0, Q_HIGH, ST_IDLE}));
    steps.push_back(pinned_step(CMD_NEW,      8'h00, '{1'b0, 8'h00, 1'b0, Q_HIGH, ST_OK}));
    steps.push_back(pinned_step(CMD_NEW,      8'hFF, '{1'b0, 8'h00, 1'b0, Q_HIGH, ST_OK}));
    steps.push_back(cmd_step(CMD_NEW, 8'hA5));
    steps.push_back(cmd_step(CMD_NEW, 8'h5A));
    // High ring now holds the limit: the next new process waits.
    steps.push_back(pinned_step(CMD_NEW,      8'h11, '{1'b0, 8'h00, 1'b0, Q_WAIT, ST_OK}));
    steps.push_back(pinned_step(CMD_EXPIRED,  8'h22, '{1'b0, 8'h00, 1'b0, Q_HIGH, ST_OK}));
    steps.push_back(cmd_step(CMD_UNBLOCK, 8'h33));
    steps.push_back(pinned_step(CMD_DISPATCH, 8'h7E, '{1'b1, 8'h00, 1'b0, Q_HIGH, ST_OK}));
    steps.push_back(pinned_step(CMD_DISPATCH, 8'h81, '{1'b1, 8'hFF, 1'b0, Q_HIGH, ST_OK}));
    // Round robin always arms the quantum.
    steps.push_back(cfg_step(REG_MODE, CfgDataWidth'(MODE_RR)));
    steps.push_back(pinned_step(CMD_DISPATCH, 8'h00, '{1'b1, 8'hA5, 1'b1, Q_HIGH, ST_OK}));
    // Feedback mode with zero admission: expiries sink to low, new ones wait.
    steps.push_back(cfg_step(REG_MODE, CfgDataWidth'(MODE_FEEDBACK)));
    steps.push_back(cfg_step(REG_LIMIT, '0));
    steps.push_back(pinned_step(CMD_EXPIRED,  8'h44, '{1'b0, 8'h00, 1'b0, Q_LOW, ST_OK}));
    steps.push_back(cmd_step(CMD_EXPIRED, 8'h88));
    steps.push_back(pinned_step(CMD_NEW,      8'h77, '{1'b0, 8'h00, 1'b0, Q_WAIT, ST_OK}));
    steps.push_back(pinned_step(CMD_DISPATCH, 8'h00, '{1'b1, 8'h5A, 1'b1, Q_HIGH, ST_OK}));
    steps.push_back(cmd_step(CMD_DISPATCH, 8'hC3));
    steps.push_back(cmd_step(CMD_DISPATCH, 8'h3C));
    steps.push_back(pinned_step(CMD_DISPATCH, 8'h00, '{1'b1, 8'h44, 1'b0, Q_LOW, ST_OK}));
    steps.push_back(pinned_step(CMD_DISPATCH, 8'h00, '{1'b1, 8'h88, 1'b0, Q_LOW, ST_OK}));
    steps.push_back(pinned_step(CMD_DISPATCH, 8'h00, '{1'b1, 8'h11, 1'b0, Q_WAIT, ST_OK}));
    steps.push_back(cmd_step(CMD_DISPATCH, 8'hFF));
    steps.push_back(pinned_step(CMD_DISPATCH, 8'h00, '{1'b0, 8'h00, 1'b0, Q_HIGH, ST_IDLE}));
    // Leave one entry in low, then switch to the reserved mode: low is not served.
    steps.push_back(pinned_step(CMD_EXPIRED,  8'h99, '{1'b0, 8'h00, 1'b0, Q_LOW, ST_OK}));
    steps.push_back(cfg_step(REG_MODE, CfgDataWidth'(MODE_RESERVED)));
    steps.push_back(cfg_step(REG_LIMIT, '1));
    steps.push_back(pinned_step(CMD_EXPIRED,  8'h66, '{1'b0, 8'h00, 1'b0, Q_HIGH, ST_OK}));
    steps.push_back(pinned_step(CMD_DISPATCH, 8'h00, '{1'b1, 8'h66, 1'b0, Q_HIGH, ST_OK}));
    steps.push_back(pinned_step(CMD_DISPATCH, 8'h00, '{1'b0, 8'h00, 1'b0, Q_HIGH, ST_IDLE}));

    // Hold reset, then release it on a falling edge.
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (steps[i]) begin
      if (steps[i].is_cfg) write_reg(steps[i].idx, steps[i].data);
      else send_cmd(steps[i].cmd, steps[i].pid, steps[i].pinned, steps[i].want, IdleLowPct);
    end

    // Random part, in phases. Each phase sets mode and limit while idle, then
    // sends a burst whose command mix is balanced or leans toward filling, draining or overflow.
    sent = 0;
    while (sent < RandomItems) begin
      kind = $urandom_range(6);
      mode = $urandom_range(1) ? MODE_FEEDBACK : ModeWidth'($urandom_range(3));
      case ($urandom_range(5))
        0:       lim = '0;
        1:       lim = LimitWidth'(1);
        2:       lim = LimitReset;
        3:       lim = LimitWidth'($urandom_range(Depth));
        4:       lim = LimitWidth'(Depth);
        default: lim = '1;
      endcase
      n = $urandom_range(20, 60);
      lane = $urandom_range(2);
      // Overflow phase: push one ring past full to hit the drop path.
      if (kind == 6) begin
        n = $urandom_range(Depth + 2, Depth + 16);
        if (lane == Q_LOW) mode = MODE_FEEDBACK;
        else if (lane == Q_WAIT) lim = '0;
        else lim = '1;
      end
      write_reg(REG_MODE, CfgDataWidth'(mode));
      write_reg(REG_LIMIT, CfgDataWidth'(lim));
      repeat (n) begin
        case (kind)
          0, 1:    cmd = $urandom_range(1) ? CMD_DISPATCH : CmdWidth'($urandom_range(2));
          2:       cmd = ($urandom_range(9) < 8) ? CmdWidth'($urandom_range(2)) : CMD_DISPATCH;
          3, 4, 5: cmd = ($urandom_range(9) < 8) ? CMD_DISPATCH : CmdWidth'($urandom_range(2));
          default: begin
            if (lane == Q_LOW) cmd = CMD_EXPIRED;
            else if (lane == Q_WAIT) cmd = CMD_NEW;
            else cmd = $urandom_range(1) ? CMD_NEW : CMD_UNBLOCK;
          end
        endcase
        // Sender idles lightly, then heavily, then not at all.
        if (sent < RandomItems / 3) idle = IdleLowPct;
        else if (sent < 2 * RandomItems / 3) idle = IdleHighPct;
        else idle = 0;
        send_cmd(cmd, PidWidth'($urandom_range(255)), 1'b0, '0, idle);
        sent++;
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
